[hdl/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the double-ended queue: command codes and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 3;

  localparam logic signed [DATA_W-1:0] ANSWER_NONE = '1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SIZE       = 3'd4,
    OP_EMPTY      = 3'd5,
    OP_PEEK_FRONT = 3'd6,
    OP_PEEK_BACK  = 3'd7
  } dq_op_e;

  typedef struct packed {
    logic   exec;      // command taken this cycle
    dq_op_e op;
    logic   load_now;  // result known at once
    logic   load_mem;  // result comes from the store read
  } dq_cmd_t;

  typedef struct packed {
    logic empty;
  } dq_status_t;

endpackage

[hdl/dq_ctrl.sv]
// ----------------------------------------------------------------------------
// dq_ctrl
// Controller: input and output handshakes, decides when a command runs and
// when the result register loads.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  dq_pkg::dq_op_e     op_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  dq_pkg::dq_status_t status_i,
  output dq_pkg::dq_cmd_t    cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   is_push;
  logic   is_mem;

  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    unique case (op_i)
      dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
        is_push = 1'b1;
        is_mem  = 1'b0;
      end
      dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK,
      dq_pkg::OP_PEEK_FRONT, dq_pkg::OP_PEEK_BACK: begin
        is_push = 1'b0;
        is_mem  = !status_i.empty;
      end
      default: begin
        is_push = 1'b0;
        is_mem  = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd_o.exec     = accept;
    cmd_o.op       = op_i;
    cmd_o.load_now = accept && !is_push && !is_mem;
    cmd_o.load_mem = (state_q == ST_READ);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && is_mem) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cmd_o.load_now || cmd_o.load_mem) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a store read always finds the result register free
  a_read_out_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> (!out_valid_q))
    else $error("result register busy during store read");

  // no new command while a store read completes
  a_read_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !in_ready_o)
    else $error("input ready during store read");

  // a memory-backed command is followed by a result load
  a_read_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_mem) |=> (cmd_o.load_mem && out_valid_d))
    else $error("store read did not load result");

endmodule

[hdl/dq_datapath.sv]
// ----------------------------------------------------------------------------
// dq_datapath
// Datapath: circular element store, head index, element count, sticky
// overflow flag and the result register.
// ----------------------------------------------------------------------------
module dq_datapath #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  dq_pkg::dq_cmd_t                     cmd_i,
  input  logic signed [dq_pkg::DATA_W-1:0]    push_value_i,
  output dq_pkg::dq_status_t                  status_o,
  output logic signed [dq_pkg::DATA_W-1:0]    answer_o,
  output logic                                overflowed_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned SW = CW + 1;
  localparam int unsigned DW = dq_pkg::DATA_W;

  logic [dq_pkg::DATA_W-1:0] mem_q [CAPACITY];
  logic [dq_pkg::DATA_W-1:0] rd_data_q;

  logic [AW-1:0] head_q, head_d;
  logic [CW-1:0] count_q, count_d;
  logic          overflow_q, overflow_d;
  logic signed [dq_pkg::DATA_W-1:0] answer_q;
  logic          overflowed_q;

  logic [SW-1:0] tail_sum;
  logic [SW-1:0] back_sum;
  logic [AW-1:0] tail_idx;
  logic [AW-1:0] back_idx;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] head_dec;
  logic          empty;
  logic          full;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic signed [dq_pkg::DATA_W-1:0] imm_answer;

  assign empty    = (count_q == '0);
  assign full     = (count_q == CW'(CAPACITY));
  assign status_o = '{empty: empty};

  assign tail_sum = SW'(head_q) + SW'(count_q);
  assign back_sum = SW'(head_q) + SW'(count_q) - SW'(1);
  assign tail_idx = (tail_sum >= SW'(CAPACITY)) ? AW'(tail_sum - SW'(CAPACITY)) : AW'(tail_sum);
  assign back_idx = (back_sum >= SW'(CAPACITY)) ? AW'(back_sum - SW'(CAPACITY)) : AW'(back_sum);
  assign head_inc = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + AW'(1);
  assign head_dec = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - AW'(1);

  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    overflow_d = overflow_q;
    wr_en      = 1'b0;
    wr_addr    = tail_idx;
    rd_en      = 1'b0;
    rd_addr    = head_q;
    imm_answer = dq_pkg::ANSWER_NONE;
    unique case (cmd_i.op)
      dq_pkg::OP_PUSH_FRONT: begin
        wr_addr = head_dec;
        if (cmd_i.exec) begin
          if (full) begin
            overflow_d = 1'b1;
          end else begin
            wr_en   = 1'b1;
            head_d  = head_dec;
            count_d = count_q + CW'(1);
          end
        end
      end
      dq_pkg::OP_PUSH_BACK: begin
        wr_addr = tail_idx;
        if (cmd_i.exec) begin
          if (full) begin
            overflow_d = 1'b1;
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
      end
      dq_pkg::OP_POP_FRONT, dq_pkg::OP_PEEK_FRONT: begin
        rd_addr = head_q;
        if (cmd_i.exec && !empty) begin
          rd_en = 1'b1;
          if (cmd_i.op == dq_pkg::OP_POP_FRONT) begin
            head_d  = head_inc;
            count_d = count_q - CW'(1);
          end
        end
      end
      dq_pkg::OP_POP_BACK, dq_pkg::OP_PEEK_BACK: begin
        rd_addr = back_idx;
        if (cmd_i.exec && !empty) begin
          rd_en = 1'b1;
          if (cmd_i.op == dq_pkg::OP_POP_BACK) begin
            count_d = count_q - CW'(1);
          end
        end
      end
      dq_pkg::OP_SIZE: begin
        imm_answer = DW'(count_q);
      end
      dq_pkg::OP_EMPTY: begin
        imm_answer = DW'(empty);
      end
      default: begin
        imm_answer = dq_pkg::ANSWER_NONE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= push_value_i;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      count_q    <= '0;
      overflow_q <= 1'b0;
    end else begin
      head_q     <= head_d;
      count_q    <= count_d;
      overflow_q <= overflow_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_now) begin
      answer_q     <= imm_answer;
      overflowed_q <= overflow_q;
    end else if (cmd_i.load_mem) begin
      answer_q     <= rd_data_q;
      overflowed_q <= overflow_q;
    end
  end

  assign answer_o     = answer_q;
  assign overflowed_o = overflowed_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("element count above capacity");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && !full && (cmd_i.op == dq_pkg::OP_PUSH_FRONT ||
     cmd_i.op == dq_pkg::OP_PUSH_BACK)) |=> (count_q == $past(count_q) + CW'(1)))
    else $error("push did not grow the deque");

  a_full_push_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.exec && full && (cmd_i.op == dq_pkg::OP_PUSH_FRONT ||
     cmd_i.op == dq_pkg::OP_PUSH_BACK)) |=> (overflow_q && $stable(count_q)))
    else $error("dropped push not flagged");

endmodule

[hdl/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue of signed 32-bit values in a circular store with push,
// pop, peek, size and empty commands and a sticky overflow flag.
// ----------------------------------------------------------------------------
// push commands give no result
// size, empty and pop/peek on an empty deque: result valid in the cycle after the transfer
// pop/peek on a non-empty deque: result passes through the registered store read and then
//   the result register; no new command is taken during the store read
// new commands are taken while a result waits, once it is being taken
// reset clears head, count, overflow flag and handshake state; the store is not cleared
module double_ended_queue #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [dq_pkg::OP_W-1:0]          op_i,
  input  logic signed [dq_pkg::DATA_W-1:0] push_value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [dq_pkg::DATA_W-1:0] answer_o,
  output logic                             overflowed_o
);

  dq_pkg::dq_cmd_t    cmd;
  dq_pkg::dq_status_t status;

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .op_i        (dq_pkg::dq_op_e'(op_i)),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  dq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .push_value_i (push_value_i),
    .status_o     (status),
    .answer_o     (answer_o),
    .overflowed_o (overflowed_o)
  );

endmodule
